/* rtl/double_hash_probe_index_defines.svh */
// ----------------------------------------------------------------------------
// Double hash probe index: assertion macros
// Shared concurrent assertion forms. They refer to clk and arst_n in the scope
// where they are used.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_PROBE_INDEX_DEFINES_SVH
`define DOUBLE_HASH_PROBE_INDEX_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DHPI_ASSERT(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("dhpi: same-cycle check failed");

// Next-cycle implication.
`define DHPI_ASSERT_NEXT(label, ant, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("dhpi: next-cycle check failed");

// Condition that must never hold.
`define DHPI_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("dhpi: forbidden condition seen");

`else

`define DHPI_ASSERT(label, ant, cons)
`define DHPI_ASSERT_NEXT(label, ant, cons)
`define DHPI_ASSERT_NEVER(label, expr)

`endif

`endif

/* rtl/dhpi_pkg.sv */
// ----------------------------------------------------------------------------
// Double hash probe index: package
// Widths, hash constants, the queued job type and the shared reduction step.
// ----------------------------------------------------------------------------
package dhpi_pkg;

	localparam int INDEX_BITS   = 24;
	localparam int ATTEMPT_BITS = 16;
	localparam int KEY_BITS     = 8;
	localparam int ACC_BITS     = 64;

	localparam int PROD_BITS = INDEX_BITS + ATTEMPT_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;
	localparam int CNT_BITS  = $clog2(ACC_BITS);

	localparam logic [ACC_BITS-1:0] DJB_SEED = ACC_BITS'(5381);
	localparam int DJB_SHIFT    = 5;
	localparam int SDBM_SHIFT_A = 6;
	localparam int SDBM_SHIFT_B = 16;

	// Depth must be a power of two so the pointers wrap on their own.
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [ACC_BITS-1:0]     djb;
		logic [ACC_BITS-1:0]     sdbm;
		logic [ATTEMPT_BITS-1:0] attempt;
	} job_t;

	// One step of restoring reduction: shift in one dividend bit and subtract
	// the modulus once if the partial remainder reaches it.
	function automatic logic [INDEX_BITS-1:0] mod_step(
		input logic [INDEX_BITS-1:0] rem,
		input logic                  din,
		input logic [INDEX_BITS-1:0] modulus
	);
		logic [INDEX_BITS:0] t;
		t = {rem, din};
		if (t >= {1'b0, modulus}) begin
			t = t - {1'b0, modulus};
		end
		return t[INDEX_BITS-1:0];
	endfunction

endpackage

/* rtl/dhpi_front.sv */
// ----------------------------------------------------------------------------
// Double hash probe index: front end
// Folds one key byte per beat into the djb2 and sdbm accumulators and hands
// the finished pair to the job queue on the last byte of a key.
// ----------------------------------------------------------------------------
`include "double_hash_probe_index_defines.svh"

module dhpi_front import dhpi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [KEY_BITS-1:0]     key_byte,
	input  logic                    key_last,
	input  logic [ATTEMPT_BITS-1:0] attempt,
	input  logic                    q_full,
	output logic                    push,
	output job_t                    push_job
);

	logic [ACC_BITS-1:0] djb_q;
	logic [ACC_BITS-1:0] sdbm_q;
	logic [ACC_BITS-1:0] djb_next;
	logic [ACC_BITS-1:0] sdbm_next;
	logic                accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && key_last;

	always_comb begin
		djb_next  = (djb_q << DJB_SHIFT) + djb_q + ACC_BITS'(key_byte);
		sdbm_next = ACC_BITS'(key_byte) + (sdbm_q << SDBM_SHIFT_A)
			+ (sdbm_q << SDBM_SHIFT_B) - sdbm_q;
	end

	assign push_job = '{djb: djb_next, sdbm: sdbm_next, attempt: attempt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			djb_q  <= DJB_SEED;
			sdbm_q <= '0;
		end else if (accept) begin
			if (key_last) begin
				djb_q  <= DJB_SEED;
				sdbm_q <= '0;
			end else begin
				djb_q  <= djb_next;
				sdbm_q <= sdbm_next;
			end
		end
	end

	// A finished key must always find room in the queue.
	`DHPI_ASSERT(a_push_has_room, push, !q_full)

endmodule

/* rtl/dhpi_queue.sv */
// ----------------------------------------------------------------------------
// Double hash probe index: job queue
// Short FIFO of finished accumulator pairs between front and back end.
// ----------------------------------------------------------------------------
`include "double_hash_probe_index_defines.svh"

module dhpi_queue import dhpi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output job_t q_job
);

	job_t                      entry_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_BITS-1:0] wr_ptr_q;
	logic [QUEUE_IDX_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      do_push;
	logic                      do_pop;

	assign full    = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_job   = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`DHPI_ASSERT_NEVER(a_count_bound, count_q > QUEUE_CNT_BITS'(QUEUE_DEPTH))

endmodule

/* rtl/dhpi_back.sv */
// ----------------------------------------------------------------------------
// Double hash probe index: back end
// Reduces both accumulators modulo the table size one bit per cycle, forms
// first + attempt * step, reduces that the same way and registers the result.
// ----------------------------------------------------------------------------
`include "double_hash_probe_index_defines.svh"

module dhpi_back import dhpi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [INDEX_BITS-1:0] modulus,
	input  logic                  q_valid,
	input  job_t                  q_job,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [INDEX_BITS-1:0] probe_index,
	output logic [INDEX_BITS-1:0] first_hash,
	output logic [INDEX_BITS-1:0] step_hash
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_HASH  = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_ADD   = 6'b001000,
		ST_PROBE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t                  state_q;
	state_t                  state_d;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [ACC_BITS-1:0]     div1_q;
	logic [ACC_BITS-1:0]     div2_q;
	logic [INDEX_BITS-1:0]   rem1_q;
	logic [INDEX_BITS-1:0]   rem2_q;
	logic [ATTEMPT_BITS-1:0] att_q;
	logic [INDEX_BITS-1:0]   first_q;
	logic [INDEX_BITS-1:0]   step_q;
	logic [PROD_BITS-1:0]    prod_q;
	logic [SUM_BITS-1:0]     sum;
	logic                    out_valid_q;
	logic [INDEX_BITS-1:0]   probe_out_q;
	logic [INDEX_BITS-1:0]   first_out_q;
	logic [INDEX_BITS-1:0]   step_out_q;
	logic                    out_free;
	logic                    load_out;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign load_out = (state_q == ST_DONE) && out_free;
	assign sum      = SUM_BITS'(first_q) + SUM_BITS'(prod_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (q_valid) state_d = ST_HASH;
			ST_HASH:  if (cnt_q == '0) state_d = ST_MUL;
			ST_MUL:   state_d = ST_ADD;
			ST_ADD:   state_d = ST_PROBE;
			ST_PROBE: if (cnt_q == '0) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers carry no reset; every job loads them before use.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				div1_q <= q_job.djb;
				div2_q <= q_job.sdbm;
				att_q  <= q_job.attempt;
				rem1_q <= '0;
				rem2_q <= '0;
				cnt_q  <= CNT_BITS'(ACC_BITS - 1);
			end
			ST_HASH: begin
				rem1_q <= mod_step(rem1_q, div1_q[ACC_BITS-1], modulus);
				rem2_q <= mod_step(rem2_q, div2_q[ACC_BITS-1], modulus);
				div1_q <= div1_q << 1;
				div2_q <= div2_q << 1;
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_MUL: begin
				first_q <= rem1_q;
				step_q  <= rem2_q;
				prod_q  <= PROD_BITS'(att_q) * PROD_BITS'(rem2_q);
			end
			ST_ADD: begin
				// Left-align the sum so the same MSB-first shifting applies.
				div1_q <= ACC_BITS'(sum) << (ACC_BITS - SUM_BITS);
				rem1_q <= '0;
				cnt_q  <= CNT_BITS'(SUM_BITS - 1);
			end
			ST_PROBE: begin
				rem1_q <= mod_step(rem1_q, div1_q[ACC_BITS-1], modulus);
				div1_q <= div1_q << 1;
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					probe_out_q <= rem1_q;
					first_out_q <= first_q;
					step_out_q  <= step_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign probe_index = probe_out_q;
	assign first_hash  = first_out_q;
	assign step_hash   = step_out_q;

	`DHPI_ASSERT_NEXT(a_hash_ends, state_q == ST_HASH && cnt_q == '0, state_q == ST_MUL)
	`DHPI_ASSERT(a_out_from_done, $rose(out_valid_q), $past(state_q == ST_DONE))

endmodule

/* rtl/double_hash_probe_index.sv */
// ----------------------------------------------------------------------------
// Double hash probe index: top level
// Streams key bytes into djb2 and sdbm accumulators and, per key, returns the
// double hashing probe slot together with both reduced hashes.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    key_byte, key_last, attempt
//   out      output     out_valid / out_stall  probe_index, first_hash, step_hash
//   cfg      input      cfg_valid / cfg_ready  table_size
//
// Key bytes are taken one per cycle while the job queue has a free slot.
// Each key then passes through the back end, paced by its one-bit-per-cycle
// restoring reduction; the back end takes no new job until the last is done.
// A two-entry job queue lets the front keep taking bytes while the back works.
// Reset sets the accumulators to their seeds and table_size to 1.
// out_stall holds the result register; in_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module double_hash_probe_index import dhpi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [KEY_BITS-1:0]     key_byte,
	input  logic                    key_last,
	input  logic [ATTEMPT_BITS-1:0] attempt,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [INDEX_BITS-1:0]   probe_index,
	output logic [INDEX_BITS-1:0]   first_hash,
	output logic [INDEX_BITS-1:0]   step_hash,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [INDEX_BITS-1:0]   table_size
);

	logic [INDEX_BITS-1:0] table_size_q;
	logic [INDEX_BITS-1:0] modulus;
	logic                  q_full;
	logic                  push;
	job_t                  push_job;
	logic                  pop;
	logic                  q_valid;
	job_t                  q_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= INDEX_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			table_size_q <= table_size;
		end
	end

	// A zero table size behaves as a single slot.
	assign modulus = (table_size_q == '0) ? INDEX_BITS'(1) : table_size_q;

	dhpi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.key_byte (key_byte),
		.key_last (key_last),
		.attempt  (attempt),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	dhpi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	dhpi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.modulus     (modulus),
		.q_valid     (q_valid),
		.q_job       (q_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.probe_index (probe_index),
		.first_hash  (first_hash),
		.step_hash   (step_hash)
	);

endmodule
